@@ hdl/sfep_pkg.sv @@
// Shared types, constants and helper functions of the spanning forest edge product block.
// No dependencies; all other block files but sfep_fifo use this package by scoped names.
package sfep_pkg;

   // Fixed widths of the beat fields.
   localparam int NODE_W   = 10;
   localparam int WEIGHT_W = 30;
   localparam int PROD_W   = 30;

   // Product modulus, 1e9 + 7.
   localparam logic [PROD_W-1:0] PROD_MOD = 30'd1000000007;

   // Full product width and the digit-serial reduction that follows the multiply.
   localparam int MUL_W       = 2 * PROD_W;
   localparam int RED_DIGIT_W = 3;
   localparam int RED_STEPS   = PROD_W / RED_DIGIT_W;
   localparam int RED_CNT_W   = 4;
   localparam int RED_V_W     = PROD_W + RED_DIGIT_W;
   localparam int RED_MULTS   = (1 << RED_DIGIT_W) - 1;

   // Epoch tags on parent entries; an entry with a stale tag reads as its own index.
   localparam int TAG_W = 8;
   localparam logic [TAG_W-1:0] EPOCH_CLEAR = '0;
   localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
   localparam logic [TAG_W-1:0] EPOCH_MAX   = {TAG_W{1'b1}};

   // Classified edge passed from the front end to the back end.
   typedef struct packed {
      logic                first_edge;
      logic                last_edge;
      logic                skip;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [PROD_W-1:0]   wmod;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic                joined;
      logic [PROD_W-1:0]   product;
      logic                final_res;
   } rsp_type;

   // Back end sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_FIND_P,
      ST_FIND_G,
      ST_MUL,
      ST_RED_HI,
      ST_RED,
      ST_EMIT
   } back_state_type;

   // Multiple k of the modulus, used by the reduction compare bank.
   function automatic logic [RED_V_W-1:0] mod_multiple(input logic [RED_DIGIT_W-1:0] k);
      logic [RED_V_W-1:0] res;
      res = RED_V_W'(k) * RED_V_W'(PROD_MOD);
      return res;
   endfunction

endpackage

@@ hdl/sfep_fifo.sv @@
// Small queue of register entries with push/full and pop/empty sides.
// Used between the front and back ends and for the result beats; depends on nothing else.
module sfep_fifo #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0]  entries_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff;
   logic [ADDR_W-1:0] rd_ptr_ff;
   logic [ADDR_W:0]   count_ff;
   logic              do_push;
   logic              do_pop;

   // Occupancy flags.
   assign full    = (count_ff == (ADDR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entries_ff[rd_ptr_ff];

   // Pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + ADDR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + ADDR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (ADDR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (ADDR_W+1)'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

@@ hdl/sfep_front.sv @@
// Front end: takes edge beats, checks endpoint range and self loops, and reduces the weight.
// Depends on sfep_pkg; feeds the command queue in front of sfep_back.
module sfep_front #(
   parameter int NODES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_first_edge,
   input  logic                          req_last_edge,
   input  logic [sfep_pkg::NODE_W-1:0]   req_node_a,
   input  logic [sfep_pkg::NODE_W-1:0]   req_node_b,
   input  logic [sfep_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                          clearing,
   input  logic                          queue_full,
   output logic                          queue_push,
   output sfep_pkg::cmd_type             queue_cmd
);

   // Indexes at or above NODES are out of range; a wide NODES leaves every index in range.
   localparam bit ALL_IN = (NODES >= (1 << sfep_pkg::NODE_W));
   localparam logic [sfep_pkg::NODE_W-1:0] NODE_LIM =
      sfep_pkg::NODE_W'(ALL_IN ? 0 : NODES);

   logic              stage_valid_ff;
   logic              stage_valid_in;
   sfep_pkg::cmd_type stage_ff;
   sfep_pkg::cmd_type stage_in;
   logic              accept;
   logic              in_range;

   // Handshake: the stage holds one beat while the queue is full.
   assign full           = clearing || (stage_valid_ff && queue_full);
   assign accept         = push && !full;
   assign queue_push     = stage_valid_ff && !queue_full;
   assign queue_cmd      = stage_ff;
   assign stage_valid_in = accept || (stage_valid_ff && queue_full);

   // Classification of the incoming edge.
   always_comb begin
      in_range = ALL_IN || ((req_node_a < NODE_LIM) && (req_node_b < NODE_LIM));
      stage_in.first_edge = req_first_edge;
      stage_in.last_edge  = req_last_edge;
      stage_in.skip       = !in_range || (req_node_a == req_node_b);
      stage_in.node_a     = req_node_a;
      stage_in.node_b     = req_node_b;
      if (req_weight >= sfep_pkg::PROD_MOD) begin
         stage_in.wmod = req_weight - sfep_pkg::PROD_MOD;
      end else begin
         stage_in.wmod = req_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

@@ hdl/sfep_back.sv @@
// Back end: union-find root searches with path halving over the parent memory, the link,
// and the modular product update. Depends on sfep_pkg; sits between the two sfep_fifo queues.
module sfep_back #(
   parameter int NODES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  sfep_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   input  logic              res_full,
   output logic              res_push,
   output sfep_pkg::rsp_type res_beat,
   output logic              clearing
);

   localparam int DEPTH   = (NODES < (1 << sfep_pkg::NODE_W)) ? NODES : (1 << sfep_pkg::NODE_W);
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int ENTRY_W = sfep_pkg::TAG_W + IDX_W;
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(DEPTH - 1);
   localparam logic [sfep_pkg::RED_CNT_W-1:0] RED_LAST =
      sfep_pkg::RED_CNT_W'(sfep_pkg::RED_STEPS - 1);

   sfep_pkg::back_state_type state_ff;
   sfep_pkg::back_state_type state_in;

   // Parent memory, one tag plus parent index per entry.
   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   // Control state.
   logic [sfep_pkg::TAG_W-1:0]  epoch_ff;
   logic [IDX_W-1:0]            clr_cnt_ff;
   logic                        clr_item_ff;
   logic [sfep_pkg::PROD_W-1:0] prod_ff;

   // Datapath state.
   sfep_pkg::cmd_type                item_ff;
   logic [IDX_W-1:0]                 cur_ff;
   logic [IDX_W-1:0]                 ra_ff;
   logic                             phase_b_ff;
   logic                             joined_ff;
   logic [sfep_pkg::MUL_W-1:0]       mul_ff;
   logic [sfep_pkg::PROD_W-1:0]      red_r_ff;
   logic [sfep_pkg::PROD_W-1:0]      red_lo_ff;
   logic [sfep_pkg::RED_CNT_W-1:0]   red_cnt_ff;

   logic [IDX_W-1:0]             node_a_idx;
   logic [IDX_W-1:0]             node_b_idx;
   logic [IDX_W-1:0]             eff_par;
   logic                         root_hit;
   logic                         wrap_clear;
   logic [sfep_pkg::PROD_W-1:0]  mul_hi;
   logic [sfep_pkg::PROD_W-1:0]  hi_red;
   logic [sfep_pkg::RED_V_W-1:0] red_v;
   logic [sfep_pkg::RED_V_W-1:0] red_sub;
   logic [sfep_pkg::PROD_W-1:0]  red_next;

   assign node_a_idx = item_ff.node_a[IDX_W-1:0];
   assign node_b_idx = item_ff.node_b[IDX_W-1:0];

   // An entry whose tag is not the current epoch is still its own parent.
   assign eff_par = (rd_data_ff[ENTRY_W-1 -: sfep_pkg::TAG_W] == epoch_ff) ?
                    rd_data_ff[IDX_W-1:0] : rd_addr_ff;
   assign root_hit   = (eff_par == cur_ff);
   assign wrap_clear = cmd_head.first_edge && (epoch_ff == sfep_pkg::EPOCH_MAX);

   // High half of the full product folded once below the modulus.
   assign mul_hi = mul_ff[sfep_pkg::MUL_W-1 -: sfep_pkg::PROD_W];
   assign hi_red = (mul_hi >= sfep_pkg::PROD_MOD) ? (mul_hi - sfep_pkg::PROD_MOD) : mul_hi;

   // One reduction step: shift in a digit, subtract the largest multiple that fits.
   always_comb begin
      red_v   = {red_r_ff, red_lo_ff[sfep_pkg::PROD_W-1 -: sfep_pkg::RED_DIGIT_W]};
      red_sub = '0;
      for (int k = 1; k <= sfep_pkg::RED_MULTS; k++) begin
         if (red_v >= sfep_pkg::mod_multiple(sfep_pkg::RED_DIGIT_W'(k))) begin
            red_sub = sfep_pkg::mod_multiple(sfep_pkg::RED_DIGIT_W'(k));
         end
      end
      red_next = sfep_pkg::PROD_W'(red_v - red_sub);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfep_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = clr_item_ff ? sfep_pkg::ST_DISPATCH : sfep_pkg::ST_IDLE;
            end
         end
         sfep_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = wrap_clear ? sfep_pkg::ST_CLEAR : sfep_pkg::ST_DISPATCH;
            end
         end
         sfep_pkg::ST_DISPATCH: begin
            state_in = item_ff.skip ? sfep_pkg::ST_EMIT : sfep_pkg::ST_FIND_P;
         end
         sfep_pkg::ST_FIND_P: begin
            if (!root_hit) begin
               state_in = sfep_pkg::ST_FIND_G;
            end else if (phase_b_ff) begin
               state_in = (ra_ff == cur_ff) ? sfep_pkg::ST_EMIT : sfep_pkg::ST_MUL;
            end
         end
         sfep_pkg::ST_FIND_G: state_in = sfep_pkg::ST_FIND_P;
         sfep_pkg::ST_MUL:    state_in = sfep_pkg::ST_RED_HI;
         sfep_pkg::ST_RED_HI: state_in = sfep_pkg::ST_RED;
         sfep_pkg::ST_RED: begin
            if (red_cnt_ff == RED_LAST) begin
               state_in = sfep_pkg::ST_EMIT;
            end
         end
         sfep_pkg::ST_EMIT: begin
            if (!res_full) begin
               state_in = sfep_pkg::ST_IDLE;
            end
         end
         default: state_in = sfep_pkg::ST_IDLE;
      endcase
   end

   // Control outputs and memory port selection.
   always_comb begin
      cmd_pop  = 1'b0;
      res_push = 1'b0;
      clearing = 1'b0;
      rd_addr  = cur_ff;
      wr_en    = 1'b0;
      wr_addr  = cur_ff;
      wr_data  = {epoch_ff, eff_par};
      case (state_ff)
         sfep_pkg::ST_CLEAR: begin
            clearing = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = clr_cnt_ff;
            wr_data  = {sfep_pkg::EPOCH_CLEAR, IDX_W'(0)};
         end
         sfep_pkg::ST_IDLE: begin
            cmd_pop = !cmd_empty;
         end
         sfep_pkg::ST_DISPATCH: begin
            rd_addr = node_a_idx;
         end
         sfep_pkg::ST_FIND_P: begin
            if (!root_hit) begin
               rd_addr = eff_par;
            end else if (!phase_b_ff) begin
               rd_addr = node_b_idx;
            end else begin
               // Link the first root under the second.
               wr_en   = (ra_ff != cur_ff);
               wr_addr = ra_ff;
               wr_data = {epoch_ff, cur_ff};
            end
         end
         sfep_pkg::ST_FIND_G: begin
            // Path halving: the node skips to its grandparent, which is read next.
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = {epoch_ff, eff_par};
            rd_addr = eff_par;
         end
         sfep_pkg::ST_EMIT: begin
            res_push = !res_full;
         end
         default: begin
            rd_addr = cur_ff;
         end
      endcase
   end

   assign res_beat.joined    = joined_ff;
   assign res_beat.product   = prod_ff;
   assign res_beat.final_res = item_ff.last_edge;

   // Parent memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sfep_pkg::ST_CLEAR;
         clr_cnt_ff  <= '0;
         clr_item_ff <= 1'b0;
         epoch_ff    <= sfep_pkg::EPOCH_FIRST;
         prod_ff     <= sfep_pkg::PROD_W'(1);
      end else begin
         state_ff <= state_in;
         case (state_ff)
            sfep_pkg::ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
               if (clr_cnt_ff == CLR_LAST) begin
                  epoch_ff    <= sfep_pkg::EPOCH_FIRST;
                  clr_item_ff <= 1'b0;
               end
            end
            sfep_pkg::ST_IDLE: begin
               if (!cmd_empty && cmd_head.first_edge) begin
                  prod_ff <= sfep_pkg::PROD_W'(1);
                  if (wrap_clear) begin
                     clr_item_ff <= 1'b1;
                     clr_cnt_ff  <= '0;
                  end else begin
                     epoch_ff <= epoch_ff + sfep_pkg::TAG_W'(1);
                  end
               end
            end
            sfep_pkg::ST_RED: begin
               if (red_cnt_ff == RED_LAST) begin
                  prod_ff <= red_next;
               end
            end
            default: begin
               clr_cnt_ff <= clr_cnt_ff;
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         sfep_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               item_ff <= cmd_head;
            end
         end
         sfep_pkg::ST_DISPATCH: begin
            cur_ff     <= node_a_idx;
            phase_b_ff <= 1'b0;
            joined_ff  <= 1'b0;
         end
         sfep_pkg::ST_FIND_P: begin
            if (root_hit && !phase_b_ff) begin
               ra_ff      <= cur_ff;
               cur_ff     <= node_b_idx;
               phase_b_ff <= 1'b1;
            end
         end
         sfep_pkg::ST_FIND_G: begin
            cur_ff <= eff_par;
         end
         sfep_pkg::ST_MUL: begin
            mul_ff    <= sfep_pkg::MUL_W'(item_ff.wmod) * sfep_pkg::MUL_W'(prod_ff);
            joined_ff <= 1'b1;
         end
         sfep_pkg::ST_RED_HI: begin
            red_r_ff   <= hi_red;
            red_lo_ff  <= mul_ff[sfep_pkg::PROD_W-1:0];
            red_cnt_ff <= '0;
         end
         sfep_pkg::ST_RED: begin
            red_r_ff   <= red_next;
            red_lo_ff  <= red_lo_ff << sfep_pkg::RED_DIGIT_W;
            red_cnt_ff <= red_cnt_ff + sfep_pkg::RED_CNT_W'(1);
         end
         default: begin
            cur_ff <= cur_ff;
         end
      endcase
   end

endmodule

@@ hdl/spanning_forest_edge_product.sv @@
// Spanning forest edge product. Edges arrive in nondecreasing weight order; each one is looked
// up in a union-find forest and, when it joins two trees, its weight modulo 1e9+7 is multiplied
// into the running product. Every edge beat yields one result beat. The back end sequencer works
// through the single read port of the parent memory: an edge with an endpoint of NODES or more,
// or a self loop, goes from dispatch straight to the result; any other edge runs the two root
// searches, with a parent write at each path-halving step; an edge that joins also runs the
// 30x30 multiply and the 3-bits-per-cycle reduction. A first edge costs nothing extra except
// on every 255th one, and right after reset, when a sweep over min(NODES, 1024) entries resets
// the parent memory; full stays high during that sweep. Two beat queues decouple the sides.
// Depends on sfep_pkg, sfep_front, sfep_fifo and sfep_back.
module spanning_forest_edge_product #(
   parameter int NODES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_first_edge,
   input  logic                          req_last_edge,
   input  logic [sfep_pkg::NODE_W-1:0]   req_node_a,
   input  logic [sfep_pkg::NODE_W-1:0]   req_node_b,
   input  logic [sfep_pkg::WEIGHT_W-1:0] req_weight,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_joined,
   output logic [sfep_pkg::PROD_W-1:0]   rsp_product,
   output logic                          rsp_final_res
);

   localparam int CMD_W = $bits(sfep_pkg::cmd_type);
   localparam int RSP_W = $bits(sfep_pkg::rsp_type);

   logic              clearing;
   logic              cmd_full;
   logic              cmd_push;
   sfep_pkg::cmd_type cmd_in;
   logic [CMD_W-1:0]  cmd_dout;
   sfep_pkg::cmd_type cmd_head;
   logic              cmd_empty;
   logic              cmd_pop;
   logic              res_full;
   logic              res_push;
   sfep_pkg::rsp_type res_beat;
   logic [RSP_W-1:0]  res_dout;
   sfep_pkg::rsp_type res_head;

   // Front end: accept and classify.
   sfep_front #(
      .NODES(NODES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_first_edge (req_first_edge),
      .req_last_edge  (req_last_edge),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .req_weight     (req_weight),
      .clearing       (clearing),
      .queue_full     (cmd_full),
      .queue_push     (cmd_push),
      .queue_cmd      (cmd_in)
   );

   // Command queue between the two halves.
   sfep_fifo #(
      .WIDTH  (CMD_W),
      .ADDR_W (1)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (CMD_W'(cmd_in)),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (cmd_dout),
      .empty (cmd_empty)
   );

   assign cmd_head = sfep_pkg::cmd_type'(cmd_dout);

   // Back end: root searches, link and product.
   sfep_back #(
      .NODES(NODES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_beat  (res_beat),
      .clearing  (clearing)
   );

   // Result queue toward the consumer.
   sfep_fifo #(
      .WIDTH  (RSP_W),
      .ADDR_W (1)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (RSP_W'(res_beat)),
      .full  (res_full),
      .pop   (pop),
      .dout  (res_dout),
      .empty (empty)
   );

   assign res_head      = sfep_pkg::rsp_type'(res_dout);
   assign rsp_joined    = res_head.joined;
   assign rsp_product   = res_head.product;
   assign rsp_final_res = res_head.final_res;

endmodule

@@ bench/spanning_forest_edge_product_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for spanning_forest_edge_product: drives edge beats, checks result beats.
// A union-find forest model predicts the results. Depends on sfep_pkg and the block's top module.
module spanning_forest_edge_product_test;

   localparam int NODE_COUNT = 1024;
   localparam int unsigned WEIGHT_MAX = 32'h3FFF_FFFF;
   localparam int unsigned MODULUS = 32'd1000000007;
   // The receiver stops popping for a long stretch after this many result beats.
   localparam int HOLD_AT = 250;
   localparam int LONG_HOLD = 400;
   // Cycles with no beat on either side before the run is declared hung.
   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 100;
   localparam int FEED_TARGET = 720;

   typedef struct {
      logic                          first_edge;
      logic                          last_edge;
      logic [sfep_pkg::NODE_W-1:0]   node_a;
      logic [sfep_pkg::NODE_W-1:0]   node_b;
      logic [sfep_pkg::WEIGHT_W-1:0] weight;
   } link_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic                          full;
   logic                          req_first_edge = 1'b0;
   logic                          req_last_edge = 1'b0;
   logic [sfep_pkg::NODE_W-1:0]   req_node_a = '0;
   logic [sfep_pkg::NODE_W-1:0]   req_node_b = '0;
   logic [sfep_pkg::WEIGHT_W-1:0] req_weight = '0;
   logic                          empty;
   logic                          pop = 1'b0;
   logic                          rsp_joined;
   logic [sfep_pkg::PROD_W-1:0]   rsp_product;
   logic                          rsp_final_res;

   // Model state of the forest and the running product.
   logic [sfep_pkg::NODE_W-1:0] forest_parent [NODE_COUNT];
   logic [sfep_pkg::PROD_W-1:0] forest_product;

   link_beat_type         edge_feed [$];
   link_beat_type         tx_beat;
   sfep_pkg::rsp_type     awaited_results [$];

   int tx_wait = 0;
   int tx_calm = 0;
   int rx_wait = 0;
   int rx_calm = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int edges_sent = 0;
   int results_seen = 0;
   int joins_seen = 0;
   int graphs_built = 0;

   spanning_forest_edge_product #(
      .NODES(NODE_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_first_edge(req_first_edge),
      .req_last_edge(req_last_edge),
      .req_node_a(req_node_a),
      .req_node_b(req_node_b),
      .req_weight(req_weight),
      .empty(empty),
      .pop(pop),
      .rsp_joined(rsp_joined),
      .rsp_product(rsp_product),
      .rsp_final_res(rsp_final_res)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Wait drawn per beat: mostly random, with occasional stretches of back-to-back beats.
   function automatic int pick_wait(inout int calm_left);
      int w;
      if (calm_left > 0) begin
         calm_left = calm_left - 1;
         w = 0;
      end else if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(8, 40);
         w = 0;
      end else begin
         w = $urandom_range(0, 10);
      end
      return w;
   endfunction

   task automatic clear_forest();
      for (int i = 0; i < NODE_COUNT; i++) begin
         forest_parent[i] = sfep_pkg::NODE_W'(i);
      end
      forest_product = sfep_pkg::PROD_W'(1);
   endtask

   // Root search with path halving, bounded by the node count.
   function automatic logic [sfep_pkg::NODE_W-1:0] root_of(input logic [sfep_pkg::NODE_W-1:0] v);
      logic [sfep_pkg::NODE_W-1:0] node;
      logic [sfep_pkg::NODE_W-1:0] up;
      bit                          done;
      node = v;
      done = 1'b0;
      for (int steps = 0; steps < NODE_COUNT && !done; steps++) begin
         up = forest_parent[node];
         if (up == node) begin
            done = 1'b1;
         end else begin
            forest_parent[node] = forest_parent[up];
            node = forest_parent[node];
         end
      end
      return node;
   endfunction

   // Applies one accepted edge to the forest and queues the result it must produce.
   task automatic predict_edge(input link_beat_type e);
      logic [sfep_pkg::NODE_W-1:0] ra;
      logic [sfep_pkg::NODE_W-1:0] rb;
      logic [63:0]                 prod;
      sfep_pkg::rsp_type           r;
      if (e.first_edge) begin
         clear_forest();
      end
      r.joined = 1'b0;
      if (int'(e.node_a) < NODE_COUNT && int'(e.node_b) < NODE_COUNT) begin
         ra = root_of(e.node_a);
         rb = root_of(e.node_b);
         if (ra != rb) begin
            prod = ((64'(e.weight) % 64'(MODULUS)) * 64'(forest_product)) % 64'(MODULUS);
            forest_product = prod[sfep_pkg::PROD_W-1:0];
            forest_parent[ra] = rb;
            r.joined = 1'b1;
            joins_seen++;
         end
      end
      r.product = forest_product;
      r.final_res = e.last_edge;
      awaited_results.push_back(r);
   endtask

   task automatic add_edge(input logic first, input logic last, input int unsigned a,
                           input int unsigned b, input int unsigned w);
      link_beat_type e;
      e.first_edge = first;
      e.last_edge = last;
      e.node_a = sfep_pkg::NODE_W'(a);
      e.node_b = sfep_pkg::NODE_W'(b);
      e.weight = sfep_pkg::WEIGHT_W'(w);
      edge_feed.push_back(e);
   endtask

   // Builds one graph of nondecreasing weights on a small window of nodes. Now and then the
   // start or end mark is dropped so that forests run into each other.
   task automatic add_graph();
      int          n_edges;
      int unsigned base;
      int unsigned span;
      int unsigned a;
      int unsigned b;
      int unsigned wv;
      int unsigned inc;
      bit          chain;
      bit          open_start;
      bit          open_end;
      n_edges = $urandom_range(1, 12);
      base = $urandom_range(0, NODE_COUNT - 1);
      span = $urandom_range(1, 16);
      chain = ($urandom_range(0, 3) == 0);
      open_start = ($urandom_range(0, 9) == 0);
      open_end = ($urandom_range(0, 9) == 0);
      wv = $urandom_range(0, WEIGHT_MAX) >> $urandom_range(0, 29);
      for (int k = 0; k < n_edges; k++) begin
         if (chain) begin
            a = (base + k) % NODE_COUNT;
            b = (base + k + 1) % NODE_COUNT;
            if ($urandom_range(0, 4) == 0) begin
               a = base;
            end
         end else begin
            a = (base + $urandom_range(0, span - 1)) % NODE_COUNT;
            b = (base + $urandom_range(0, span - 1)) % NODE_COUNT;
         end
         if ($urandom_range(0, 19) == 0) begin
            // Zero weight, or the modulus itself when the weight is not above it, wipes the product.
            wv = (wv == 0) ? 0 : ((wv <= MODULUS) ? MODULUS : wv);
         end else begin
            inc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1000);
            wv = (wv + inc > WEIGHT_MAX) ? WEIGHT_MAX : wv + inc;
         end
         add_edge(k == 0 && !open_start, k == n_edges - 1 && !open_end, a, b, wv);
      end
      graphs_built++;
   endtask

   // Stimulus: directed graphs first, then random graphs mixed with noise beats.
   initial begin
      clear_forest();

      // Extreme endpoints and weights, a closed cycle and a self loop.
      add_edge(1'b1, 1'b0, 0, 1023, WEIGHT_MAX);
      add_edge(1'b0, 1'b0, 1023, 0, WEIGHT_MAX);
      add_edge(1'b0, 1'b0, 512, 512, WEIGHT_MAX);
      add_edge(1'b0, 1'b0, 1, 2, WEIGHT_MAX);
      add_edge(1'b0, 1'b0, 2, 0, WEIGHT_MAX);
      add_edge(1'b0, 1'b1, 1, 1023, WEIGHT_MAX);
      // A long chain, then a cycle across it so the root search halves a deep path.
      for (int k = 0; k < 8; k++) begin
         add_edge(k == 0, 1'b0, 100 + k, 101 + k, 1 + k);
      end
      add_edge(1'b0, 1'b0, 100, 108, 9);
      add_edge(1'b0, 1'b1, 100, 200, MODULUS - 1);
      // A first edge on nodes that were joined before must join again.
      add_edge(1'b1, 1'b1, 100, 108, 5);
      // Zero weight makes the product zero and it stays there.
      add_edge(1'b1, 1'b0, 3, 4, 0);
      add_edge(1'b0, 1'b1, 4, 5, 5);
      // A weight equal to the modulus, and one just below it.
      add_edge(1'b1, 1'b1, 6, 7, MODULUS);
      add_edge(1'b1, 1'b1, 6, 7, MODULUS - 1);
      graphs_built += 7;

      while (edge_feed.size() < FEED_TARGET) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               add_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, WEIGHT_MAX));
            end
         end else begin
            add_graph();
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait until every edge has gone in and every result has come back.
      @(posedge clock);
      while (edge_feed.size() != 0 || push || awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d edges in about %0d graphs plus noise beats; %0d joined the forest.",
               edges_sent, graphs_built, joins_seen);
      $display("Checked %0d result beats with %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0) begin
         $display("spanning_forest_edge_product regression: pass");
      end else begin
         $display("spanning_forest_edge_product regression: fail");
      end
      $finish;
   end

   // Driver: presents the next edge beat after a random wait and holds it while full is high.
   always @(posedge clock) begin : drive
      int w;
      if (reset) begin
         push <= 1'b0;
         tx_wait <= 0;
      end else if (push && full) begin
         // The beat stays on the ports until the block takes it.
      end else if (push) begin
         predict_edge(tx_beat);
         edges_sent++;
         w = pick_wait(tx_calm);
         if (w == 0 && edge_feed.size() != 0) begin
            tx_beat = edge_feed.pop_front();
            req_first_edge <= tx_beat.first_edge;
            req_last_edge <= tx_beat.last_edge;
            req_node_a <= tx_beat.node_a;
            req_node_b <= tx_beat.node_b;
            req_weight <= tx_beat.weight;
         end else begin
            push <= 1'b0;
            tx_wait <= w;
         end
      end else if (tx_wait > 0) begin
         tx_wait <= tx_wait - 1;
      end else if (edge_feed.size() != 0) begin
         tx_beat = edge_feed.pop_front();
         req_first_edge <= tx_beat.first_edge;
         req_last_edge <= tx_beat.last_edge;
         req_node_a <= tx_beat.node_a;
         req_node_b <= tx_beat.node_b;
         req_weight <= tx_beat.weight;
         push <= 1'b1;
      end
   end

   // Monitor: pops result beats after a random wait and checks each against the oldest
   // expectation. One long hold lets the block fill up and push back on the sender.
   always @(posedge clock) begin : watch
      sfep_pkg::rsp_type want;
      int                w;
      if (reset) begin
         pop <= 1'b0;
         rx_wait <= 0;
      end else if (pop && !empty) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: result beat with nothing expected: joined %0b product %0d last %0b",
                     $time, rsp_joined, rsp_product, rsp_final_res);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_joined !== want.joined) begin
               $display("%0t: joined mismatch: expected %0b, actual %0b",
                        $time, want.joined, rsp_joined);
               mismatches++;
            end
            if (rsp_product !== want.product) begin
               $display("%0t: product mismatch: expected %0d, actual %0d",
                        $time, want.product, rsp_product);
               mismatches++;
            end
            if (rsp_final_res !== want.final_res) begin
               $display("%0t: final_res mismatch: expected %0b, actual %0b",
                        $time, want.final_res, rsp_final_res);
               mismatches++;
            end
         end
         results_seen++;
         w = pick_wait(rx_calm);
         if (results_seen == HOLD_AT) begin
            w = LONG_HOLD;
         end
         rx_wait <= w;
         pop <= (w == 0);
      end else if (rx_wait > 0) begin
         rx_wait <= rx_wait - 1;
         pop <= (rx_wait == 1);
      end else begin
         pop <= 1'b1;
      end
   end

   // Watchdog: a long run of cycles with no beat on either side means the block is stuck.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("spanning_forest_edge_product regression: fail");
            $finish;
         end
      end
   end

endmodule
